@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros; they expand to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_PROP(lbl, clk, rst, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ hw/rtl/dvbp_pkg.sv @@
// -----------------------------------------------------------------------------
// dvbp_pkg
// Shared types, constants and helpers of the delta varint block packer.
// -----------------------------------------------------------------------------
package dvbp_pkg;

  localparam logic [2:0] ADDR_BLOCK_SIZE  = 3'd0;
  localparam logic [9:0] BLOCK_SIZE_RESET = 10'd512;
  localparam logic [9:0] BLOCK_SIZE_MIN   = 10'd16;
  localparam logic [9:0] HEADER_BYTES     = 10'd2;
  localparam int unsigned StoreCap        = 512;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_INDEX = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FLUSH,
    B_KEY,
    B_VAL,
    B_SINGLE
  } back_state_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic        is_close;
    logic        pre_flush;
    logic        post_flush;
    logic        opened;
    logic        write_kd;
    logic [31:0] kd;
    logic [31:0] vd;
    logic [31:0] key;
    logic [15:0] flush_items;
    logic [31:0] checksum;
    logic [31:0] block_total;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] data_word;
    logic [3:0]  data_bytes;
    logic        index_valid;
    logic [31:0] index_key;
    logic [31:0] checksum;
    logic [31:0] block_total;
    logic        last;
  } result_t;

  function automatic logic [2:0] vsize(input logic [31:0] v);
    logic [2:0] n;
    if (v[31:7] == 25'd0) n = 3'd1;
    else if (v[31:14] == 18'd0) n = 3'd2;
    else if (v[31:21] == 11'd0) n = 3'd3;
    else if (v[31:28] == 4'd0) n = 3'd4;
    else n = 3'd5;
    return n;
  endfunction

  function automatic logic [9:0] eff_size(input logic [9:0] bs, input logic [9:0] hi);
    logic [9:0] s;
    s = bs;
    if (s < BLOCK_SIZE_MIN) s = BLOCK_SIZE_MIN;
    if (s > hi) s = hi;
    return s;
  endfunction

endpackage

@@ hw/rtl/dvbp_ram.sv @@
// -----------------------------------------------------------------------------
// dvbp_ram
// Generic single write port, single read port RAM with registered read.
// -----------------------------------------------------------------------------
module dvbp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/dvbp_front.sv @@
// -----------------------------------------------------------------------------
// dvbp_front
// Accepts words, computes deltas and varint sizes, decides flushes.
// -----------------------------------------------------------------------------
module dvbp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_clear,
  input  logic [9:0]        eff,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic [31:0]       in_key,
  input  logic [31:0]       in_value,
  input  logic              q_full,
  output logic              q_push,
  output dvbp_pkg::cmd_t    q_data
);

  logic [9:0]  fill;
  logic [15:0] items;
  logic [31:0] prev_key;
  logic [31:0] prev_value;
  logic [31:0] xor_sum;
  logic [31:0] blocks;

  logic [31:0] kd, vd, vd_w;
  logic [2:0]  ksz, vsz, vsz_w;
  logic [10:0] cur;
  logic        pre, post, write_kd, has_items;
  logic [9:0]  fill_a;
  logic [15:0] items_a;
  logic [9:0]  nbytes;

  always_comb begin
    has_items = (items != 16'd0);
    kd        = has_items ? (in_key - prev_key) : 32'hffff_ffff;
    vd        = (kd != 32'd0) ? in_value : (in_value - prev_value);
    ksz       = dvbp_pkg::vsize(kd);
    vsz       = dvbp_pkg::vsize(vd);
    cur       = {1'b0, fill} + {1'b0, dvbp_pkg::HEADER_BYTES}
              + (has_items ? {8'd0, ksz} : 11'd0) + {8'd0, vsz};
    pre       = cur > {1'b0, eff};
    post      = cur == {1'b0, eff};
    vd_w      = pre ? in_value : vd;
    vsz_w     = dvbp_pkg::vsize(vd_w);
    items_a   = pre ? 16'd0 : items;
    fill_a    = pre ? 10'd0 : fill;
    write_kd  = (items_a != 16'd0);
    nbytes    = (write_kd ? {7'd0, ksz} : 10'd0) + {7'd0, vsz_w};

    q_push = in_valid && !q_full;
    q_data = '0;
    if (in_cmd) begin
      q_data.is_close    = 1'b1;
      q_data.pre_flush   = has_items;
      q_data.flush_items = items;
      q_data.checksum    = xor_sum;
      q_data.block_total = blocks + {31'd0, has_items};
    end else begin
      q_data.pre_flush   = pre;
      q_data.post_flush  = post;
      q_data.opened      = !write_kd;
      q_data.write_kd    = write_kd;
      q_data.kd          = kd;
      q_data.vd          = vd_w;
      q_data.key         = in_key;
      q_data.flush_items = pre ? items : (items + 16'd1);
      q_data.checksum    = xor_sum ^ in_key ^ in_value;
      q_data.block_total = blocks + {31'd0, pre} + {31'd0, post};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      items      <= '0;
      prev_key   <= '0;
      prev_value <= '0;
      xor_sum    <= '0;
      blocks     <= '0;
    end else if (cfg_clear) begin
      fill  <= '0;
      items <= '0;
    end else if (q_push) begin
      xor_sum <= q_data.checksum;
      blocks  <= q_data.block_total;
      if (in_cmd) begin
        if (has_items) begin
          fill  <= '0;
          items <= '0;
        end
      end else begin
        prev_key   <= in_key;
        prev_value <= in_value;
        if (post) begin
          fill  <= '0;
          items <= '0;
        end else begin
          fill  <= fill_a + nbytes;
          items <= items_a + 16'd1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/dvbp_cmd_queue.sv @@
// -----------------------------------------------------------------------------
// dvbp_cmd_queue
// Two-entry queue of classified words between front and back.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvbp_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dvbp_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dvbp_pkg::cmd_t head
);

  dvbp_pkg::cmd_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty)

endmodule

@@ hw/rtl/dvbp_back.sv @@
// -----------------------------------------------------------------------------
// dvbp_back
// Writes varint bytes into the block store and streams flushes and reports.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvbp_back #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_clear,
  input  logic [9:0]        eff,
  input  logic              q_empty,
  input  dvbp_pkg::cmd_t    q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output dvbp_pkg::result_t out_res
);

  localparam int AW = $clog2(DEPTH);

  dvbp_pkg::back_state_t state, state_next;
  dvbp_pkg::cmd_t        cur_cmd;
  dvbp_pkg::result_t     res;
  logic                  ovalid;
  logic                  post;
  logic                  rd_pend;
  logic [6:0]            w;
  logic [9:0]            pos;
  logic [63:0]           asm_word;
  logic [31:0]           vshift;

  logic        out_free, last_w, flush_load, ram_re, ram_we, stepping, byte_last;
  logic        single_load;
  logic [6:0]  words, pos_word, raddr7;
  logic [10:0] eff_p7;
  logic [2:0]  tail, lane;
  logic [7:0]  vb;
  logic [63:0] ins, asm_new, fw, rdata;

  always_comb begin
    out_free    = !ovalid || !out_stall;
    eff_p7      = {1'b0, eff} + 11'd7;
    words       = eff_p7[9:3];
    tail        = eff[2:0];
    pos_word    = pos[9:3];
    last_w      = (w == words - 7'd1);
    flush_load  = (state == dvbp_pkg::B_FLUSH) && rd_pend && out_free;
    ram_re      = (state == dvbp_pkg::B_FLUSH) && (!rd_pend || (out_free && !last_w));
    raddr7      = rd_pend ? (w + 7'd1) : w;
    stepping    = (state == dvbp_pkg::B_KEY) || (state == dvbp_pkg::B_VAL);
    byte_last   = (vshift[31:7] == 25'd0);
    vb          = {!byte_last, vshift[6:0]};
    lane        = pos[2:0];
    ins         = {56'd0, vb} << {(3'd7 - lane), 3'b000};
    asm_new     = asm_word | ins;
    ram_we      = stepping && (lane == 3'd7);
    single_load = (state == dvbp_pkg::B_SINGLE) && out_free;

    // words below the write point come from the store, the open word from
    // the assembly register, anything past it reads as zero padding
    if (w < pos_word) fw = rdata;
    else if (w == pos_word) fw = asm_word;
    else fw = 64'd0;
    if (w == 7'd0) fw[63:48] = cur_cmd.flush_items;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      dvbp_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.pre_flush) state_next = dvbp_pkg::B_FLUSH;
          else if (q_data.is_close) state_next = dvbp_pkg::B_SINGLE;
          else if (q_data.write_kd) state_next = dvbp_pkg::B_KEY;
          else state_next = dvbp_pkg::B_VAL;
        end
      end
      dvbp_pkg::B_FLUSH: begin
        if (flush_load && last_w) begin
          state_next = (cur_cmd.is_close || post) ? dvbp_pkg::B_IDLE : dvbp_pkg::B_VAL;
        end
      end
      dvbp_pkg::B_KEY: begin
        if (byte_last) state_next = dvbp_pkg::B_VAL;
      end
      dvbp_pkg::B_VAL: begin
        if (byte_last) begin
          if (cur_cmd.post_flush) state_next = dvbp_pkg::B_FLUSH;
          else if (cur_cmd.opened && !cur_cmd.pre_flush) state_next = dvbp_pkg::B_SINGLE;
          else state_next = dvbp_pkg::B_IDLE;
        end
      end
      dvbp_pkg::B_SINGLE: begin
        if (out_free) state_next = dvbp_pkg::B_IDLE;
      end
      default: state_next = dvbp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvbp_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      post     <= 1'b0;
      rd_pend  <= 1'b0;
      w        <= '0;
      pos      <= dvbp_pkg::HEADER_BYTES;
      asm_word <= '0;
    end else if (cfg_clear) begin
      pos      <= dvbp_pkg::HEADER_BYTES;
      asm_word <= '0;
    end else begin
      if (q_pop) begin
        post    <= 1'b0;
        rd_pend <= 1'b0;
        w       <= '0;
      end
      if (state == dvbp_pkg::B_FLUSH) begin
        if (ram_re) rd_pend <= 1'b1;
        else if (flush_load) rd_pend <= 1'b0;
        if (flush_load) begin
          w <= w + 7'd1;
          if (last_w) begin
            pos      <= dvbp_pkg::HEADER_BYTES;
            asm_word <= '0;
          end
        end
      end
      if (stepping) begin
        pos      <= pos + 10'd1;
        asm_word <= (lane == 3'd7) ? 64'd0 : asm_new;
        if (state == dvbp_pkg::B_VAL && byte_last && cur_cmd.post_flush) begin
          post    <= 1'b1;
          rd_pend <= 1'b0;
          w       <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd <= q_data;
      vshift  <= q_data.write_kd ? q_data.kd : q_data.vd;
    end else if (stepping) begin
      vshift <= (state == dvbp_pkg::B_KEY && byte_last) ? cur_cmd.vd : (vshift >> 7);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (flush_load || single_load) begin
      ovalid <= 1'b1;
    end else if (!out_stall) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush_load) begin
      res.kind        <= dvbp_pkg::KIND_DATA;
      res.data_word   <= fw;
      res.data_bytes  <= (last_w && tail != 3'd0) ? {1'b0, tail} : 4'd8;
      res.index_valid <= cur_cmd.opened && last_w;
      res.index_key   <= (cur_cmd.opened && last_w) ? cur_cmd.key : 32'd0;
      res.checksum    <= cur_cmd.checksum;
      res.block_total <= cur_cmd.block_total;
      res.last        <= last_w;
    end else if (single_load) begin
      res.kind        <= cur_cmd.is_close ? dvbp_pkg::KIND_CLOSE : dvbp_pkg::KIND_INDEX;
      res.data_word   <= 64'd0;
      res.data_bytes  <= 4'd0;
      res.index_valid <= cur_cmd.opened;
      res.index_key   <= cur_cmd.opened ? cur_cmd.key : 32'd0;
      res.checksum    <= cur_cmd.checksum;
      res.block_total <= cur_cmd.block_total;
      res.last        <= 1'b1;
    end
  end

  assign out_valid = ovalid;
  assign out_res   = res;

  dvbp_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos[AW+2:3]),
    .wdata(asm_new),
    .re   (ram_re),
    .raddr(raddr7[AW-1:0]),
    .rdata(rdata)
  );

  `ASSERT_PROP(a_pos_in_block, clk, rst, pos <= eff)
  `ASSERT_PROP(a_flush_in_range, clk, rst, (state == dvbp_pkg::B_FLUSH) |-> (w < words))
  `ASSERT_PROP(a_marker_last, clk, rst, (ovalid && res.kind != dvbp_pkg::KIND_DATA) |-> res.last)

endmodule

@@ hw/rtl/delta_varint_block_packer_unit.sv @@
// -----------------------------------------------------------------------------
// delta_varint_block_packer_unit
// Packs sorted key/value pairs into fixed-size blocks of varint deltas.
// -----------------------------------------------------------------------------
// Words on the input are either an add (cmd 0) or a close (cmd 1). A front
// end takes one word per cycle while its two-entry queue has room, works out
// the key/value deltas and their varint sizes, and decides whether the word
// flushes a block before or after its bytes land. The back end then writes
// the varint bytes into the block store one byte per cycle. A flush streams
// ceil(effective block size/8) 64-bit words from a registered store read,
// at one per cycle while the output does not stall; the store is a single
// 64-bit wide RAM and only one byte a cycle is assembled into it. A close
// without an open block, or an add that opens a block without a flush,
// produces one marker word. An add that neither opens nor fills a block
// produces nothing. Every block word carries the running checksum and block
// count; last marks the final output word of each input word. block_size is
// applied clamped to 16..min(MAX_BLOCK_BYTES, 512) and writing it drops the
// partial block. No clearing pass is needed: store locations past the write
// point read as zero padding.
// -----------------------------------------------------------------------------
module delta_varint_block_packer_unit #(
  parameter int MAX_BLOCK_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [31:0]           key,
  input  logic [31:0]           value,
  // output words
  output logic                  out_valid,
  input  logic                  out_stall,
  output dvbp_pkg::kind_t       kind,
  output logic [63:0]           data_word,
  output logic [3:0]            data_bytes,
  output logic                  index_valid,
  output logic [31:0]           index_key,
  output logic [31:0]           checksum,
  output logic [31:0]           block_total,
  output logic                  last
);

  // largest usable block, in bytes, and store depth in 64-bit words
  localparam int CapBytes = (MAX_BLOCK_BYTES < dvbp_pkg::StoreCap)
                          ? MAX_BLOCK_BYTES : dvbp_pkg::StoreCap;
  localparam int StoreWords = (CapBytes + 7) / 8;

  logic [9:0]        block_size;
  logic [9:0]        eff;
  logic              cfg_clear;
  logic              q_push, q_full, q_pop, q_empty;
  dvbp_pkg::cmd_t    q_in, q_head;
  dvbp_pkg::result_t res;

  // register file: one register, block_size
  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && (paddr == dvbp_pkg::ADDR_BLOCK_SIZE);
  assign prdata    = (paddr == dvbp_pkg::ADDR_BLOCK_SIZE) ? {22'd0, block_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= dvbp_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_clear) begin
      block_size <= pwdata[9:0];
    end
  end

  assign eff      = dvbp_pkg::eff_size(block_size, CapBytes[9:0]);
  assign in_stall = q_full;

  dvbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_clear(cfg_clear),
    .eff      (eff),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_key   (key),
    .in_value (value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  dvbp_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  dvbp_back #(
    .DEPTH(StoreWords)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_clear(cfg_clear),
    .eff      (eff),
    .q_empty  (q_empty),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res)
  );

  assign kind        = res.kind;
  assign data_word   = res.data_word;
  assign data_bytes  = res.data_bytes;
  assign index_valid = res.index_valid;
  assign index_key   = res.index_key;
  assign checksum    = res.checksum;
  assign block_total = res.block_total;
  assign last        = res.last;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb - delta varint block packer testbench
// Drives add and close words with random gaps and output stalls, steps the
// block size through several settings over the APB port, and checks every
// output word against a behavioral predictor of the block packing.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // expected output words and their checking
  class packer_scoreboard;
    dvbp_pkg::result_t want_q[$];
    int                errors;

    function void note_words(dvbp_pkg::result_t words[$]);
      foreach (words[i]) want_q = {want_q, words[i]};
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // one printed line per mismatch
    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_word(dvbp_pkg::result_t got);
      dvbp_pkg::result_t w;
      if (want_q.size() == 0) begin
        report("unexpected word", got.data_word, 0);
        return;
      end
      w = want_q.pop_front();
      if (got.kind != w.kind) report("kind", got.kind, w.kind);
      if (got.data_word != w.data_word) report("data_word", got.data_word, w.data_word);
      if (got.data_bytes != w.data_bytes) report("data_bytes", got.data_bytes, w.data_bytes);
      if (got.index_valid != w.index_valid)
        report("index_valid", got.index_valid, w.index_valid);
      if (got.index_key != w.index_key) report("index_key", got.index_key, w.index_key);
      if (got.checksum != w.checksum) report("checksum", got.checksum, w.checksum);
      if (got.block_total != w.block_total)
        report("block_total", got.block_total, w.block_total);
      if (got.last != w.last) report("last", got.last, w.last);
    endtask
  endclass

  logic            clk, rst;
  logic            psel, penable, pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata, prdata;
  logic            pready;
  logic            in_valid, in_stall, cmd;
  logic [31:0]     key, value;
  logic            out_valid, out_stall;
  dvbp_pkg::kind_t kind;
  logic [63:0]     data_word;
  logic [3:0]      data_bytes;
  logic            index_valid;
  logic [31:0]     index_key, checksum, block_total;
  logic            last;

  delta_varint_block_packer_unit uut (.*);

  packer_scoreboard sb = new();

  // predictor state
  logic [7:0]  pk_store [dvbp_pkg::StoreCap];
  logic [9:0]  pk_fill;
  logic [15:0] pk_items;
  logic [31:0] pk_prev_key, pk_prev_val, pk_blocks, pk_xor;
  logic [9:0]  pk_bsize;

  bit quiet;  // no idling on either side while set

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic int varint_len(logic [31:0] v);
    if (v < 32'h80) return 1;
    if (v < 32'h4000) return 2;
    if (v < 32'h20_0000) return 3;
    if (v < 32'h1000_0000) return 4;
    return 5;
  endfunction

  function automatic int clamped_size();
    int s;
    s = pk_bsize;
    if (s < 16) s = 16;
    if (s > 512) s = 512;
    return s;
  endfunction

  function automatic void clear_block();
    foreach (pk_store[i]) pk_store[i] = 8'h00;
    pk_fill = 0;
    pk_items = 0;
  endfunction

  function automatic void store_varint(logic [31:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      if (pk_fill < dvbp_pkg::StoreCap) pk_store[pk_fill] = b;
      pk_fill = pk_fill + 10'd1;
    end while (v != 0);
  endfunction

  // emits the block as 64-bit words: count header then zero padded store
  function automatic void flush_words(ref dvbp_pkg::result_t words[$]);
    int                eff, nw;
    dvbp_pkg::result_t r;
    logic [7:0]        b;
    eff = clamped_size();
    nw = (eff + 7) / 8;
    for (int w = 0; w < nw; w++) begin
      r = '0;
      r.kind = dvbp_pkg::KIND_DATA;
      for (int j = 0; j < 8; j++) begin
        int i;
        i = w * 8 + j;
        b = 0;
        if (i < eff) begin
          r.data_bytes++;
          if (i == 0) b = pk_items[15:8];
          else if (i == 1) b = pk_items[7:0];
          else b = pk_store[i - 2];
        end
        r.data_word = {r.data_word[55:0], b};
      end
      words = {words, r};
    end
    clear_block();
    pk_blocks++;
  endfunction

  // expected words for one accepted input word
  function automatic void pack_word(logic c, logic [31:0] k, logic [31:0] v);
    dvbp_pkg::result_t words[$];
    dvbp_pkg::result_t r;
    logic [31:0] kd, vd;
    int         eff, cur;
    bit         opened;
    opened = 0;
    if (c) begin
      if (pk_items != 0) flush_words(words);
      if (words.size() == 0) begin
        r = '0;
        r.kind = dvbp_pkg::KIND_CLOSE;
        words = {words, r};
      end
    end else begin
      eff = clamped_size();
      pk_xor ^= k ^ v;
      kd = (pk_items != 0) ? k - pk_prev_key : 32'hFFFF_FFFF;
      vd = (kd != 0) ? v : v - pk_prev_val;
      cur = pk_fill + 2 + ((pk_items != 0) ? varint_len(kd) : 0) + varint_len(vd);
      // pair overflows: flush first and restart deltas
      if (cur > eff) begin
        flush_words(words);
        kd = k;
        vd = v;
      end
      if (pk_items != 0) store_varint(kd);
      else opened = 1;
      store_varint(vd);
      pk_prev_key = k;
      pk_prev_val = v;
      pk_items++;
      if (cur == eff) flush_words(words);  // exactly full
      if (opened) begin
        if (words.size() == 0) begin
          r = '0;
          r.kind = dvbp_pkg::KIND_INDEX;
          words = {words, r};
        end
        words[$].index_valid = 1;
        words[$].index_key = k;
      end
    end
    foreach (words[i]) begin
      words[i].checksum = pk_xor;
      words[i].block_total = pk_blocks;
      words[i].last = (i == words.size() - 1);
    end
    sb.note_words(words);
  endfunction

  // output side: random stall, sample accepted words
  always @(negedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 16);

  always @(posedge clk) begin
    dvbp_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = kind;
      got.data_word = data_word;
      got.data_bytes = data_bytes;
      got.index_valid = index_valid;
      got.index_key = index_key;
      got.checksum = checksum;
      got.block_total = block_total;
      got.last = last;
      sb.check_word(got);
    end
  end

  task automatic send_word(logic c, logic [31:0] k, logic [31:0] v);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_stall);
    pack_word(c, k, v);
    @(negedge clk);
  endtask

  // drain, let trailing no-result adds settle, then write the size
  task automatic set_block_size(logic [31:0] sz);
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= dvbp_pkg::ADDR_BLOCK_SIZE;
    pwdata <= sz;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    pk_bsize = sz[9:0];
    clear_block();
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  function automatic logic [31:0] rand_bits();
    int w;
    w = $urandom_range(1, 32);
    return (w == 32) ? $urandom : ($urandom & ((32'h1 << w) - 1));
  endfunction

  logic [31:0] gen_key, gen_val;

  // mostly sorted pairs, some unsorted noise
  task automatic send_random();
    int r;
    bit same;
    r = $urandom_range(99);
    if (r < 6) begin
      send_word(1, $urandom, $urandom);
      return;
    end
    r = $urandom_range(99);
    same = 0;
    if (r < 30) same = 1;
    else if (r < 60) gen_key += $urandom_range(1, 127);
    else if (r < 82) gen_key += rand_bits();
    else if (r < 92) gen_key = $urandom;
    if (same && $urandom_range(99) < 70) gen_val += ($urandom_range(1) ? rand_bits() : 0);
    else gen_val = rand_bits();
    send_word(0, gen_key, gen_val);
  endtask

  initial begin
    int sizes[9] = '{16, 0, 1023, 37, 100, 17, 24, 64, 0};
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; cmd = 0; key = 0; value = 0; out_stall = 0;
    quiet = 0;
    gen_key = 0; gen_val = 0;
    pk_prev_key = 0; pk_prev_val = 0; pk_blocks = 0; pk_xor = 0;
    pk_bsize = dvbp_pkg::BLOCK_SIZE_RESET;
    clear_block();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset size, empty close, field extremes, repeat keys
    send_word(1, 32'h0, 32'h0);
    send_word(0, 32'h0, 32'h0);
    send_word(0, 32'h0, 32'hFFFF_FFFF);
    send_word(0, 32'h0, 32'hFFFF_FFFF);
    send_word(0, 32'h7F, 32'h80);
    send_word(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(1, 32'h0, 32'h0);
    send_word(0, 32'h1000_0000, 32'h3FFF);
    send_word(0, 32'h5, 32'h1);  // unsorted, delta wraps
    // smallest block: overflow quickly
    set_block_size(16);
    send_word(0, 32'h10, 32'hFFFF_FFFF);
    send_word(0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_word(0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_word(0, 32'hFFFF_FFF1, 32'h2);
    send_word(0, 32'hFFFF_FFF2, 32'h3);
    send_word(1, 32'h0, 32'h0);
    // size write after the close, with no block open
    set_block_size(16);

    for (int p = 0; p < 9; p++) begin
      int sz;
      sz = sizes[p];
      if (p == 8) sz = $urandom_range(16, 80);
      set_block_size(sz);
      quiet = (p == 3);
      for (int n = 0; n < 22; n++) send_random();
    end
    in_valid <= 0;
    quiet = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
